// ===== rtl/indexed_linked_list_manager_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the indexed linked list manager
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LINKED_LIST_MANAGER_CORE_DEFINES_SVH
`define INDEXED_LINKED_LIST_MANAGER_CORE_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define ILM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that holds in the cycle after the antecedent.
`define ILM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ilm_pkg.sv =====
// ---------------------------------------------------------------------------
// ilm_pkg
// Sizes, codes and transfer types of the indexed linked list manager.
// ---------------------------------------------------------------------------
package ilm_pkg;

  localparam int SLOTS      = 64;
  localparam int VALUE_BITS = 32;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LINK_W = $clog2(SLOTS + 1);
  localparam int VAL_W  = VALUE_BITS;

  // Fixed field widths of the transfer payloads
  localparam int CMD_FW    = 3;
  localparam int VALUE_FW  = 32;
  localparam int POS_FW    = 6;
  localparam int STATUS_FW = 2;
  localparam int SLOT_FW   = 6;

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(SLOTS);

  localparam logic [CMD_FW-1:0] CMD_PUSH_TAIL = 3'd0;
  localparam logic [CMD_FW-1:0] CMD_PUSH_HEAD = 3'd1;
  localparam logic [CMD_FW-1:0] CMD_POP_TAIL  = 3'd2;
  localparam logic [CMD_FW-1:0] CMD_POP_HEAD  = 3'd3;
  localparam logic [CMD_FW-1:0] CMD_INSERT    = 3'd4;

  localparam logic [STATUS_FW-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_FW-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_FW-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_FW-1:0] ST_UNUSED = 2'd3;

  typedef struct packed {
    logic [CMD_FW-1:0]   cmd;
    logic [VALUE_FW-1:0] value;
    logic [POS_FW-1:0]   position;
  } in_t;

  typedef struct packed {
    logic [VALUE_FW-1:0]  out_value;
    logic [STATUS_FW-1:0] status;
    logic [SLOT_FW-1:0]   slot;
  } out_t;

  typedef struct packed {
    logic              used;
    logic [LINK_W-1:0] prev_link;
    logic [LINK_W-1:0] next_link;
  } link_t;

  // Sequencer request to the link store: one read and one write per cycle
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              we_used;
    logic              we_prev;
    logic              we_next;
    logic              val_we;
    link_t             wr_link;
  } lnk_req_t;

endpackage

// ===== rtl/ilm_link_store.sv =====
// ---------------------------------------------------------------------------
// ilm_link_store
// Slot table: link, in-use and value memories with registered reads.
// ---------------------------------------------------------------------------
module ilm_link_store
  import ilm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lnk_req_t         req,
  input  logic [VAL_W-1:0] val_wdata,
  output link_t            rd_link,
  output logic [VAL_W-1:0] rd_value
);

  logic [LINK_W-1:0] next_mem [SLOTS];
  logic [LINK_W-1:0] prev_mem [SLOTS];
  logic              used_mem [SLOTS];
  logic [VAL_W-1:0]  val_mem  [SLOTS];

  // An entry never written reads as its reset link pattern
  logic [SLOTS-1:0]  vld_r;

  logic [LINK_W-1:0] rd_next_r;
  logic [LINK_W-1:0] rd_prev_r;
  logic              rd_used_r;
  logic              rd_vld_r;
  logic [SLOT_W-1:0] rd_addr_r;
  logic [VAL_W-1:0]  rd_value_r;

  logic [LINK_W-1:0] wr_def_next;
  logic [LINK_W-1:0] rd_def_next;

  assign wr_def_next = LINK_W'(req.wr_addr) + LINK_W'(1);
  assign rd_def_next = LINK_W'(rd_addr_r) + LINK_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // Fields not written on the first write of an entry take their reset value
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      if (req.we_next || !vld_r[req.wr_addr]) begin
        next_mem[req.wr_addr] <= req.we_next ? req.wr_link.next_link : wr_def_next;
      end
      if (req.we_prev || !vld_r[req.wr_addr]) begin
        prev_mem[req.wr_addr] <= req.we_prev ? req.wr_link.prev_link : NONE_LINK;
      end
      if (req.we_used || !vld_r[req.wr_addr]) begin
        used_mem[req.wr_addr] <= req.we_used ? req.wr_link.used : 1'b0;
      end
    end
    if (req.val_we) begin
      val_mem[req.wr_addr] <= val_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_next_r  <= next_mem[req.rd_addr];
      rd_prev_r  <= prev_mem[req.rd_addr];
      rd_used_r  <= used_mem[req.rd_addr];
      rd_vld_r   <= vld_r[req.rd_addr];
      rd_addr_r  <= req.rd_addr;
      rd_value_r <= val_mem[req.rd_addr];
    end
  end

  assign rd_link.used      = rd_vld_r ? rd_used_r : 1'b0;
  assign rd_link.prev_link = rd_vld_r ? rd_prev_r : NONE_LINK;
  assign rd_link.next_link = rd_vld_r ? rd_next_r : rd_def_next;
  assign rd_value          = rd_value_r;

endmodule

// ===== rtl/ilm_seq.sv =====
// ---------------------------------------------------------------------------
// ilm_seq
// Command sequencer: list ends, free chain, count and link-store steps.
// ---------------------------------------------------------------------------
`include "indexed_linked_list_manager_core_defines.svh"

module ilm_seq
  import ilm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             res_valid,
  input  logic             res_ack,
  output out_t             res,
  output lnk_req_t         req,
  output logic [VAL_W-1:0] val_wdata,
  input  link_t            rd_link,
  input  logic [VAL_W-1:0] rd_value
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_POS_RD = 8'b0000_0100,
    S_TAKE   = 8'b0000_1000,
    S_POP    = 8'b0001_0000,
    S_LINK_A = 8'b0010_0000,
    S_LINK_B = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]    first_r, first_nxt;
  logic [SLOT_W-1:0]    last_r, last_nxt;
  logic [LINK_W-1:0]    free_r, free_nxt;
  logic [LINK_W-1:0]    count_r, count_nxt;

  logic [CMD_FW-1:0]    cmd_r, cmd_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [POS_FW-1:0]    pos_r, pos_nxt;
  logic [LINK_W-1:0]    nx_r, nx_nxt;
  logic [SLOT_W-1:0]    nb_r, nb_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 mid_r, mid_nxt;
  logic [STATUS_FW-1:0] status_r, status_nxt;
  logic [VAL_W-1:0]     outv_r, outv_nxt;

  logic              is_pop;
  logic              is_push;
  logic              full;
  logic              pos_ok;
  logic              is_mid;
  logic [SLOT_W-1:0] pop_slot;
  logic [SLOT_W-1:0] free_slot;
  logic [LINK_W-1:0] pop_nb;

  assign is_pop    = (cmd_r == CMD_POP_TAIL) || (cmd_r == CMD_POP_HEAD);
  assign is_push   = (cmd_r == CMD_PUSH_TAIL) || (cmd_r == CMD_PUSH_HEAD) ||
                     (cmd_r == CMD_INSERT);
  assign full      = (count_r >= LINK_W'(SLOTS)) || (free_r >= NONE_LINK);
  assign pos_ok    = int'(pos_r) < SLOTS;
  assign is_mid    = (cmd_r == CMD_INSERT) && (SLOT_W'(pos_r) != last_r);
  assign pop_slot  = (cmd_r == CMD_POP_TAIL) ? last_r : first_r;
  assign free_slot = free_r[SLOT_W-1:0];
  assign pop_nb    = (cmd_r == CMD_POP_TAIL) ? rd_link.prev_link : rd_link.next_link;

  always_comb begin
    state_nxt  = state_r;
    first_nxt  = first_r;
    last_nxt   = last_r;
    free_nxt   = free_r;
    count_nxt  = count_r;
    cmd_nxt    = cmd_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    nx_nxt     = nx_r;
    nb_nxt     = nb_r;
    slot_nxt   = slot_r;
    mid_nxt    = mid_r;
    status_nxt = status_r;
    outv_nxt   = outv_r;
    req        = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          val_nxt   = VAL_W'(in_data.value);
          pos_nxt   = in_data.position;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        status_nxt = ST_OK;
        outv_nxt   = '0;
        slot_nxt   = '0;
        mid_nxt    = 1'b0;
        state_nxt  = S_DONE;
        if (is_pop) begin
          if (count_r != '0) begin
            slot_nxt    = pop_slot;
            req.rd_en   = 1'b1;
            req.rd_addr = pop_slot;
            state_nxt   = S_POP;
          end else begin
            status_nxt = ST_EMPTY;
          end
        end else if (is_push) begin
          if (full) begin
            status_nxt = ST_FULL;
          end else if (cmd_r == CMD_INSERT) begin
            if (pos_ok) begin
              req.rd_en   = 1'b1;
              req.rd_addr = SLOT_W'(pos_r);
              state_nxt   = S_POS_RD;
            end else begin
              status_nxt = ST_UNUSED;
            end
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = free_slot;
            state_nxt   = S_TAKE;
          end
        end
      end

      S_POS_RD: begin
        if (!rd_link.used) begin
          status_nxt = ST_UNUSED;
          state_nxt  = S_DONE;
        end else begin
          nx_nxt      = rd_link.next_link;
          req.rd_en   = 1'b1;
          req.rd_addr = free_slot;
          state_nxt   = S_TAKE;
        end
      end

      S_TAKE: begin
        req.wr_en             = 1'b1;
        req.wr_addr           = free_slot;
        req.we_used           = 1'b1;
        req.we_prev           = 1'b1;
        req.we_next           = 1'b1;
        req.val_we            = 1'b1;
        req.wr_link.used      = 1'b1;
        req.wr_link.prev_link = NONE_LINK;
        req.wr_link.next_link = NONE_LINK;
        free_nxt  = rd_link.next_link;
        count_nxt = count_r + LINK_W'(1);
        slot_nxt  = free_slot;
        mid_nxt   = is_mid;
        state_nxt = S_DONE;
        if (cmd_r == CMD_PUSH_HEAD) begin
          nb_nxt    = first_r;
          first_nxt = free_slot;
          if (count_r == '0) begin
            last_nxt = free_slot;
          end else begin
            req.wr_link.next_link = LINK_W'(first_r);
            state_nxt             = S_LINK_A;
          end
        end else if (is_mid) begin
          req.wr_link.prev_link = LINK_W'(pos_r);
          req.wr_link.next_link = nx_r;
          nb_nxt    = SLOT_W'(pos_r);
          state_nxt = S_LINK_A;
          if (nx_r >= NONE_LINK) begin
            last_nxt = free_slot;
          end
        end else begin
          // push at tail, or insert after the tail
          nb_nxt   = last_r;
          last_nxt = free_slot;
          if (count_r == '0) begin
            first_nxt = free_slot;
          end else begin
            req.wr_link.prev_link = LINK_W'(last_r);
            state_nxt             = S_LINK_A;
          end
        end
      end

      S_POP: begin
        outv_nxt              = rd_value;
        req.wr_en             = 1'b1;
        req.wr_addr           = slot_r;
        req.we_used           = 1'b1;
        req.we_prev           = 1'b1;
        req.we_next           = 1'b1;
        req.wr_link.used      = 1'b0;
        req.wr_link.prev_link = NONE_LINK;
        req.wr_link.next_link = free_r;
        free_nxt  = LINK_W'(slot_r);
        count_nxt = count_r - LINK_W'(1);
        if ((count_r > LINK_W'(1)) && (pop_nb < NONE_LINK)) begin
          nb_nxt = pop_nb[SLOT_W-1:0];
          if (cmd_r == CMD_POP_TAIL) begin
            last_nxt = pop_nb[SLOT_W-1:0];
          end else begin
            first_nxt = pop_nb[SLOT_W-1:0];
          end
          state_nxt = S_LINK_A;
        end else begin
          first_nxt = '0;
          last_nxt  = '0;
          state_nxt = S_DONE;
        end
      end

      S_LINK_A: begin
        req.wr_en   = 1'b1;
        req.wr_addr = nb_r;
        if (cmd_r == CMD_PUSH_HEAD) begin
          req.we_prev           = 1'b1;
          req.wr_link.prev_link = LINK_W'(slot_r);
        end else if (cmd_r == CMD_POP_TAIL) begin
          req.we_next           = 1'b1;
          req.wr_link.next_link = NONE_LINK;
        end else if (cmd_r == CMD_POP_HEAD) begin
          req.we_prev           = 1'b1;
          req.wr_link.prev_link = NONE_LINK;
        end else begin
          req.we_next           = 1'b1;
          req.wr_link.next_link = LINK_W'(slot_r);
        end
        state_nxt = (mid_r && (nx_r < NONE_LINK)) ? S_LINK_B : S_DONE;
      end

      S_LINK_B: begin
        req.wr_en             = 1'b1;
        req.wr_addr           = nx_r[SLOT_W-1:0];
        req.we_prev           = 1'b1;
        req.wr_link.prev_link = LINK_W'(slot_r);
        state_nxt             = S_DONE;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= '0;
      last_r  <= '0;
      free_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    nx_r     <= nx_nxt;
    nb_r     <= nb_nxt;
    slot_r   <= slot_nxt;
    mid_r    <= mid_nxt;
    status_r <= status_nxt;
    outv_r   <= outv_nxt;
  end

  assign val_wdata     = val_r;
  assign res.out_value = VALUE_FW'(outv_r);
  assign res.status    = status_r;
  assign res.slot      = SLOT_FW'(slot_r);

  `ILM_ASSERT_ALWAYS(a_count_range, count_r <= LINK_W'(SLOTS), "item count beyond table size")
  `ILM_ASSERT_ALWAYS(a_free_vs_count, (free_r == NONE_LINK) == (count_r == LINK_W'(SLOTS)), "free chain and item count disagree")
  `ILM_ASSERT_ALWAYS(a_empty_ends, (count_r != '0) || ((first_r == '0) && (last_r == '0)), "empty list with stale ends")
  `ILM_ASSERT_NEXT(a_take_count, state_r == S_TAKE, count_r == $past(count_r) + LINK_W'(1), "slot taken without count step")

endmodule

// ===== rtl/indexed_linked_list_manager_core.sv =====
// ---------------------------------------------------------------------------
// indexed_linked_list_manager_core
// Doubly linked list in a fixed slot table with a free-slot chain.
// ---------------------------------------------------------------------------
//  Channel | Ports                          | Payload
//  --------+--------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data    | cmd, value, position
//  out     | out_valid, out_ready, out_data | out_value, status, slot
//
//  Steps: a command holds the block from its input transfer to the earliest
//    next one, set by the single read and write port of the link store:
//    decode, one or two reads (insert position, free top or popped slot),
//    then the slot write and up to two neighbour writes. The result reaches
//    out_valid in the same cycle as the next command can first transfer.
//  Pop from empty, push when full and unknown commands end after decode,
//    an insert after an unused slot after the position read; push onto an
//    empty list and pop from a one-element list write no neighbour, and
//    only an insert in mid-list writes two.
//  Reset: synchronous, active low; list ends, free top and count clear at
//    once, and per-slot valid flags restore the initial link chain, so no
//    clearing pass is needed.
//  Stalls: a result waits in the output register while the next command is
//    accepted and worked on; the sequencer holds only if a second result is
//    ready before the first has been taken.
// ---------------------------------------------------------------------------
module indexed_linked_list_manager_core
  import ilm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  lnk_req_t         req;
  link_t            rd_link;
  logic [VAL_W-1:0] rd_value;
  logic [VAL_W-1:0] val_wdata;

  logic res_valid;
  logic res_ack;
  out_t res;

  logic out_valid_r;
  out_t out_data_r;

  // Sequencer: owns list ends, free top and count, drives the link store
  ilm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res       (res),
    .req       (req),
    .val_wdata (val_wdata),
    .rd_link   (rd_link),
    .rd_value  (rd_value)
  );

  // Slot table: links, in-use flags and element values
  ilm_link_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .val_wdata (val_wdata),
    .rd_link   (rd_link),
    .rd_value  (rd_value)
  );

  // Output register: load when empty or when the waiting result transfers
  assign res_ack = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload until it transfers
  always_ff @(posedge clk) begin
    if (res_valid && res_ack) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/ilm_list_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ilm_list_checker
// Watches both channels of the list manager, keeps its own copy of the slot
// table and free chain, works out the result of every accepted command and
// compares each returned result against the oldest one still owed.
// ---------------------------------------------------------------------------
module ilm_list_checker
  import ilm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   n_errors,
  output int   n_pending
);

  logic [VAL_W-1:0]  slot_val  [SLOTS];
  logic [LINK_W-1:0] link_next [SLOTS];
  logic [LINK_W-1:0] link_prev [SLOTS];
  logic              slot_busy [SLOTS];
  logic [LINK_W-1:0] list_head, list_tail, free_head;
  int unsigned       item_total;

  out_t owed_q[$];
  out_t owed;
  int   err_cnt = 0;

  task automatic log_mismatch(input string msg);
    $display("checker @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Apply one command to the shadow list and return the result it owes
  function automatic out_t predict_list_op(input in_t c);
    out_t              r;
    logic [LINK_W-1:0] s, nb, p;
    r        = '0;
    r.status = ST_OK;
    p        = LINK_W'(c.position);
    case (c.cmd)
      CMD_PUSH_TAIL, CMD_PUSH_HEAD, CMD_INSERT: begin
        if (item_total >= SLOTS || free_head >= SLOTS) begin
          r.status = ST_FULL;
        end else if (c.cmd == CMD_INSERT && !slot_busy[c.position]) begin
          r.status = ST_UNUSED;
        end else begin
          s                          = free_head;
          free_head                  = link_next[s[SLOT_W-1:0]];
          slot_val[s[SLOT_W-1:0]]    = c.value[VAL_W-1:0];
          slot_busy[s[SLOT_W-1:0]]   = 1'b1;
          link_next[s[SLOT_W-1:0]]   = NONE_LINK;
          link_prev[s[SLOT_W-1:0]]   = NONE_LINK;
          item_total++;
          r.slot = s[SLOT_FW-1:0];
          if (c.cmd == CMD_PUSH_HEAD) begin
            if (item_total > 1 && list_head < SLOTS) begin
              link_next[s[SLOT_W-1:0]]         = list_head;
              link_prev[list_head[SLOT_W-1:0]] = s;
            end else begin
              list_tail = s;
            end
            list_head = s;
          end else if (c.cmd == CMD_PUSH_TAIL || p == list_tail) begin
            if (item_total > 1 && list_tail < SLOTS) begin
              link_prev[s[SLOT_W-1:0]]         = list_tail;
              link_next[list_tail[SLOT_W-1:0]] = s;
            end else begin
              list_head = s;
            end
            list_tail = s;
          end else begin
            nb                       = link_next[p[SLOT_W-1:0]];
            link_prev[s[SLOT_W-1:0]] = p;
            link_next[s[SLOT_W-1:0]] = nb;
            link_next[p[SLOT_W-1:0]] = s;
            if (nb < SLOTS) link_prev[nb[SLOT_W-1:0]] = s;
            else list_tail = s;
          end
        end
      end
      CMD_POP_TAIL, CMD_POP_HEAD: begin
        s = (c.cmd == CMD_POP_TAIL) ? list_tail : list_head;
        if (item_total == 0 || s >= SLOTS) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = VALUE_FW'(slot_val[s[SLOT_W-1:0]]);
          r.slot      = s[SLOT_FW-1:0];
          if (c.cmd == CMD_POP_TAIL) begin
            nb = link_prev[s[SLOT_W-1:0]];
            if (item_total > 1 && nb < SLOTS) begin
              link_next[nb[SLOT_W-1:0]] = NONE_LINK;
              list_tail                 = nb;
            end else begin
              list_head = '0;
              list_tail = '0;
            end
          end else begin
            nb = link_next[s[SLOT_W-1:0]];
            if (item_total > 1 && nb < SLOTS) begin
              link_prev[nb[SLOT_W-1:0]] = NONE_LINK;
              list_head                 = nb;
            end else begin
              list_head = '0;
              list_tail = '0;
            end
          end
          // freed slot goes back on top of the free chain
          slot_busy[s[SLOT_W-1:0]] = 1'b0;
          link_prev[s[SLOT_W-1:0]] = NONE_LINK;
          link_next[s[SLOT_W-1:0]] = free_head;
          free_head                = s;
          item_total--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        link_next[i] = LINK_W'(i + 1);
        link_prev[i] = NONE_LINK;
        slot_busy[i] = 1'b0;
      end
      list_head  = '0;
      list_tail  = '0;
      free_head  = '0;
      item_total = 0;
      owed_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          log_mismatch($sformatf("result with nothing owed: %h", out_data));
        end else begin
          owed = owed_q.pop_front();
          if (out_data.out_value !== owed.out_value)
            log_mismatch($sformatf("out_value %h, want %h", out_data.out_value,
                                   owed.out_value));
          if (out_data.status !== owed.status)
            log_mismatch($sformatf("status %0d, want %0d", out_data.status, owed.status));
          if (out_data.slot !== owed.slot)
            log_mismatch($sformatf("slot %0d, want %0d", out_data.slot, owed.slot));
        end
      end
      if (in_valid && in_ready) owed_q.push_back(predict_list_op(in_data));
    end
    n_pending <= owed_q.size();
    n_errors  <= err_cnt;
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives command transfers into the linked list manager: a directed opening
// over empty, single-element, mid-list and unknown-command cases, then
// random phases that fill the table towards full, churn it and drain it to empty.
// Both sides idle at random; the checker alongside owns all comparison.
// ---------------------------------------------------------------------------
module tb;
  import ilm_pkg::*;

  // Spare command codes that the block must treat as no-ops
  localparam logic [CMD_FW-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_FW-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_FW-1:0] CMD_SPARE_HI = 3'd7;

  // Random phase shapes
  localparam int PH_MIXED = 0;
  localparam int PH_FILL  = 1;
  localparam int PH_DRAIN = 2;

  localparam int HOLD_AT     = 250;  // transfers sent before the long hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000; // cycles without any transfer

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int n_errors;
  int n_pending;
  int n_sent    = 0;
  int idle_run  = 0;
  bit send_calm = 0;

  indexed_linked_list_manager_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ilm_list_checker checker_i (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .n_errors (n_errors),
    .n_pending(n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one command after a random gap and hold it until the block takes
  // it. Gaps vanish for stretches so that back-to-back transfers occur too.
  task automatic send_cmd(input logic [CMD_FW-1:0] op, input logic [VALUE_FW-1:0] val,
                          input logic [POS_FW-1:0] pos);
    int  gap;
    in_t item;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap           = send_calm ? 0 : $urandom_range(0, 17);
    item.cmd      = op;
    item.value    = val;
    item.position = pos;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!(in_valid && in_ready));
    n_sent++;
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
  endtask

  // Fill phases only push and insert, so the table grows towards full; drain phases
  // pop only, so it always reaches empty. Mixed phases lean slightly towards
  // growth so that inserts often land on slots in use.
  task automatic run_phase(input int shape, input int count);
    int                  pick;
    logic [CMD_FW-1:0]   op;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      case (shape)
        PH_FILL:  op = (pick < 45) ? CMD_PUSH_TAIL : (pick < 90) ? CMD_PUSH_HEAD : CMD_INSERT;
        PH_DRAIN: op = (pick < 50) ? CMD_POP_TAIL : CMD_POP_HEAD;
        default: begin
          if (pick < 18)      op = CMD_PUSH_TAIL;
          else if (pick < 36) op = CMD_PUSH_HEAD;
          else if (pick < 54) op = CMD_POP_TAIL;
          else if (pick < 72) op = CMD_POP_HEAD;
          else if (pick < 96) op = CMD_INSERT;
          else                op = CMD_FW'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        end
      endcase
      send_cmd(op, $urandom, POS_FW'($urandom_range(0, 63)));
    end
  endtask

  // Receiver: random stall before each result, calm stretches with none,
  // and one long hold-off once enough traffic has gone in so that the
  // block backs up and drops in_ready.
  initial begin : receiver
    int gap;
    bit calm;
    bit held_off;
    out_ready = 1'b0;
    calm      = 0;
    held_off  = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_off && n_sent >= HOLD_AT) begin
        held_off = 1;
        gap      = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 29) == 0) calm = !calm;
        gap = calm ? 0 : $urandom_range(0, 17);
      end
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Watchdog: end the run if no transfer moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= STALL_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening; slots come off the reset free chain in order
    send_cmd(CMD_POP_TAIL, 32'h0, 6'd0);          // empty list
    send_cmd(CMD_POP_HEAD, 32'h0, 6'd63);         // empty list
    send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 6'd0);    // unused position on empty list
    send_cmd(CMD_INSERT, 32'h1234_5678, 6'd63);
    send_cmd(CMD_PUSH_TAIL, 32'h0, 6'd0);         // first element, slot 0
    send_cmd(CMD_PUSH_HEAD, 32'hFFFF_FFFF, 6'd63); // slot 1 at head
    send_cmd(CMD_PUSH_TAIL, 32'hA5A5_5A5A, 6'd0); // slot 2 at tail
    send_cmd(CMD_INSERT, $urandom, 6'd2);         // after the tail: acts as push tail
    send_cmd(CMD_INSERT, $urandom, 6'd1);         // mid-list after the head
    send_cmd(CMD_INSERT, $urandom, 6'd0);         // mid-list after slot 0
    send_cmd(CMD_INSERT, $urandom, 6'd63);        // unused position, list not empty
    send_cmd(CMD_SPARE_LO, 32'hFFFF_FFFF, 6'd63);
    send_cmd(CMD_SPARE_MID, $urandom, 6'd1);
    send_cmd(CMD_SPARE_HI, 32'h0, 6'd0);
    send_cmd(CMD_POP_HEAD, 32'h0, 6'd0);
    send_cmd(CMD_POP_TAIL, 32'h0, 6'd0);
    send_cmd(CMD_PUSH_HEAD, $urandom, 6'd0);      // reuse a freed slot
    repeat (6) send_cmd(CMD_POP_TAIL, 32'h0, 6'd0); // run past empty
    send_cmd(CMD_PUSH_TAIL, $urandom, 6'd0);      // lone element
    send_cmd(CMD_POP_HEAD, 32'h0, 6'd0);

    run_phase(PH_MIXED, 60);
    run_phase(PH_FILL, 80);
    run_phase(PH_MIXED, 150);
    wait_for_results();
    run_phase(PH_DRAIN, 75);
    run_phase(PH_MIXED, 60);
    run_phase(PH_FILL, 70);
    run_phase(PH_MIXED, 60);

    wait_for_results();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
